/* src/hpe_pkg.sv */
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types and constants for the half-space polytope engine.
// ----------------------------------------------------------------------------
package hpe_pkg;

  localparam int MODE_W  = 3;
  localparam int COORD_W = 16;
  localparam int OPV_W   = 32;
  localparam int ID_W    = 16;
  localparam int CNT_W   = 7;
  localparam int DIM_W   = 3;
  localparam int RAD_W   = 16;
  localparam int IN_W    = 120;
  localparam int OUT_W   = 32;
  localparam int CFG_IW  = 2;

  localparam logic [ID_W-1:0] NO_ID = 16'hFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_CUT_OFFSET = 3'd0,
    MODE_CUT_SPHERE = 3'd1,
    MODE_ENLARGE    = 3'd2,
    MODE_INSIDE     = 3'd3,
    MODE_NEIGHBOUR  = 3'd4
  } mode_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_DIMENSION    = 2'd0,
    REG_CHART_RADIUS = 2'd1,
    REG_OUTER_RADIUS = 2'd2
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_NSUM = 6'b000100,
    ST_INS  = 6'b001000,
    ST_WALK = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

/* src/halfspace_polytope_engine.sv */
// ----------------------------------------------------------------------------
// halfspace_polytope_engine
// Table of half-space faces with insert, enlarge, inside and neighbour ops.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis_*, one operation per word; each word gives
// exactly one result word on m_axis_*. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no operation is
// in flight; the block does not enforce it. Inserts (modes 0 and 1) pass
// from accept through the prep, norm-sum and insert states to the finish
// state. Enlarge, inside test and neighbour search walk the stored faces
// one per cycle through the single read port of the face memories. One
// word is worked on at a time; the next word is taken once the engine is
// back in idle, even while the previous result still waits.
// A stalled receiver holds the result in the output register; a finished
// operation waits there until the register frees up.
// Reset (rst, synchronous) empties the table and restores the registers
// to dimension 2, chart radius 1.0 and outer radius 2.0. The face
// memories are not cleared: only entries below the face count are read.
// ----------------------------------------------------------------------------
module halfspace_polytope_engine #(
  parameter int MAX_FACES = 64,
  parameter int MAX_DIM   = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // mode, coord_0, coord_1, coord_2, coord_3, operand_value, face_id, zero pad
  input  logic [hpe_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // inside_res, neighbour_found, neighbour_id, face_count, table_full, zero pad
  output logic [hpe_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        cfg_we,
  input  logic [hpe_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [hpe_pkg::RAD_W-1:0]   cfg_data
);
  import hpe_pkg::*;

  localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CW = $clog2(MAX_FACES + 1);
  localparam int NW = MAX_DIM * COORD_W;

  state_t state;

  logic [DIM_W-1:0] dimension;
  logic [RAD_W-1:0] chart_radius;
  logic [RAD_W-1:0] outer_radius;

  logic [CW-1:0] count;

  // latched item
  logic [MODE_W-1:0]                    mode;
  logic [MAX_DIM-1:0][COORD_W-1:0]      t;
  logic signed [OPV_W-1:0]              opv;
  logic [ID_W-1:0]                      fid;

  logic [31:0]          sq [MAX_DIM];
  logic [31:0]          rc2;
  logic [31:0]          oc2;
  logic signed [63:0]   op2;
  logic [33:0]          norm;
  logic [33:0]          norm_next;

  // walk pipeline
  logic [CW-1:0]        rd_idx;
  logic                 v1, v2, v3;
  logic [AW-1:0]        idx1, idx2, idx3;
  logic signed [31:0]   off2, off3;
  logic [ID_W-1:0]      id2, id3;
  logic signed [31:0]   prod [MAX_DIM];
  logic signed [34:0]   fval;
  logic signed [34:0]   fval_next;
  logic                 viol_any;
  logic                 found;
  logic [ID_W-1:0]      first_id;
  logic                 full;

  // memories
  logic                 n_we, o_we, i_we;
  logic [AW-1:0]        waddr, o_waddr, raddr;
  logic [NW-1:0]        n_rdata;
  logic [OPV_W-1:0]     o_wdata, o_rdata;
  logic [ID_W-1:0]      i_rdata;

  logic [DIM_W-1:0]     k;
  logic                 issue;
  logic                 walk_done;
  logic signed [63:0]   s_val, neg_val, half_val;
  logic signed [31:0]   ins_off;
  logic signed [35:0]   grown;
  logic signed [31:0]   grown_sat;
  logic                 can_ins;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    if (dimension == '0) begin
      k = DIM_W'(1);
    end else if (32'(dimension) > MAX_DIM) begin
      k = DIM_W'(MAX_DIM);
    end else begin
      k = dimension;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension    <= DIM_W'(2);
      chart_radius <= RAD_W'(4096);
      outer_radius <= RAD_W'(8192);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMENSION:    dimension    <= cfg_data[DIM_W-1:0];
        REG_CHART_RADIUS: chart_radius <= cfg_data;
        REG_OUTER_RADIUS: outer_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // norm and insert offset
  always_comb begin
    norm_next = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      norm_next = norm_next + 34'(sq[j]);
    end
    s_val    = $signed({32'd0, rc2}) - op2 + $signed({30'd0, norm});
    neg_val  = -s_val;
    half_val = neg_val >>> 1;
    ins_off  = (mode == MODE_CUT_SPHERE) ? sat32(half_val) : opv;
    can_ins  = (fid != NO_ID) && (count != CW'(MAX_FACES));
  end

  // face value and enlarged offset
  always_comb begin
    fval_next = 35'(off2);
    for (int j = 0; j < MAX_DIM; j++) begin
      fval_next = fval_next + 35'(prod[j]);
    end
    grown     = 36'(off3) - 36'(fval);
    grown_sat = sat32(64'(grown));
  end

  assign issue     = (state == ST_WALK) && (rd_idx != count);
  assign walk_done = (state == ST_WALK) && !issue && !v1 && !v2 && !v3;
  assign raddr     = rd_idx[AW-1:0];
  assign waddr     = count[AW-1:0];

  assign n_we    = (state == ST_INS) && can_ins;
  assign i_we    = n_we;
  assign o_we    = n_we || (v3 && mode == MODE_ENLARGE && fval > 0);
  assign o_waddr = n_we ? waddr : idx3;
  assign o_wdata = n_we ? ins_off : grown_sat;

  hpe_ram #(.W(NW), .D(MAX_FACES)) u_normal (
    .clk(clk), .we(n_we), .waddr(waddr), .wdata(t),
    .raddr(raddr), .rdata(n_rdata)
  );

  hpe_ram #(.W(OPV_W), .D(MAX_FACES)) u_offset (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(raddr), .rdata(o_rdata)
  );

  hpe_ram #(.W(ID_W), .D(MAX_FACES)) u_id (
    .clk(clk), .we(i_we), .waddr(waddr), .wdata(fid),
    .raddr(raddr), .rdata(i_rdata)
  );

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode <= s_axis_tdata[2:0];
      for (int j = 0; j < MAX_DIM; j++) begin
        // zero the coordinates past the active dimension
        t[j] <= (j < 32'(k)) ? s_axis_tdata[3 + 16*j +: 16] : '0;
      end
      opv <= s_axis_tdata[98:67];
      fid <= s_axis_tdata[114:99];
    end
    for (int j = 0; j < MAX_DIM; j++) begin
      sq[j] <= 32'($signed(t[j]) * $signed(t[j]));
    end
    rc2  <= 32'(chart_radius) * 32'(chart_radius);
    oc2  <= 32'(outer_radius) * 32'(outer_radius);
    op2  <= 64'(opv) * 64'(opv);
    norm <= norm_next;
    // walk stages
    idx1 <= raddr;
    idx2 <= idx1;
    off2 <= o_rdata;
    id2  <= i_rdata;
    for (int j = 0; j < MAX_DIM; j++) begin
      prod[j] <= $signed(n_rdata[16*j +: 16]) * $signed(t[j]);
    end
    idx3 <= idx2;
    off3 <= off2;
    id3  <= id2;
    fval <= fval_next;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      rd_idx        <= '0;
      viol_any      <= 1'b0;
      found         <= 1'b0;
      first_id      <= NO_ID;
      full          <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (v3 && fval > 0) begin
        viol_any <= 1'b1;
        if (!found) begin
          found    <= 1'b1;
          first_id <= id3;
        end
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            rd_idx   <= '0;
            viol_any <= 1'b0;
            found    <= 1'b0;
            first_id <= NO_ID;
            full     <= 1'b0;
            state    <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_NSUM;
        ST_NSUM: begin
          if (mode == MODE_CUT_OFFSET || mode == MODE_CUT_SPHERE) begin
            state <= ST_INS;
          end else if (mode == MODE_ENLARGE || mode == MODE_INSIDE
                       || mode == MODE_NEIGHBOUR) begin
            state <= ST_WALK;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_INS: begin
          if (can_ins) begin
            count <= count + CW'(1);
          end
          full  <= (fid != NO_ID) && (count == CW'(MAX_FACES));
          state <= ST_FIN;
        end
        ST_WALK: begin
          if (walk_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic res_inside, res_found;
  logic [ID_W-1:0] res_id;

  always_comb begin
    res_inside = (mode == MODE_INSIDE) && ({2'b0, oc2} >= norm) && !viol_any;
    res_found  = (mode == MODE_NEIGHBOUR) && ({2'b0, rc2} >= norm) && found;
    res_id     = res_found ? first_id : NO_ID;
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {6'd0, full, CNT_W'(count), res_id, res_found, res_inside};
    end
  end

  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_FACES)
    else $error("face count beyond table depth");

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_PREP)
    else $error("accepted word did not start an operation");

  assert property (@(posedge clk) disable iff (rst)
    issue |-> state == ST_WALK && rd_idx < count)
    else $error("face read outside the stored range");

endmodule

/* src/hpe_ram.sv */
// ----------------------------------------------------------------------------
// hpe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpe_ram #(
  parameter int W  = 16,
  parameter int D  = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
